// ----- hw/rtl/ftvt_pkg.sv -----
// ----------------------------------------------------------------------------
// ftvt_pkg
// shared types, codes and constants of the tag=value tokenizer
// ----------------------------------------------------------------------------
package ftvt_pkg;

    localparam int TAG_BITS_DEF    = 32;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int TAG_W    = 32;
    localparam int OFS_W    = 16;
    localparam int INDEX_W  = 8;
    localparam int ERR_W    = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [BYTE_W-1:0] ASCII_EQ   = 8'h3D;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    localparam logic [BYTE_W-1:0] FIELD_LIMIT_RST = 8'd64;
    localparam logic [BYTE_W-1:0] FIELD_SEP_RST   = 8'd1;
    localparam logic [INDEX_W-1:0] FIELD_COUNT_MAX = 8'd255;

    // register index, taken from paddr[2]
    localparam logic REG_FIELD_LIMIT = 1'b0;
    localparam logic REG_FIELD_SEP   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_FIELD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;

    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MISSING_EQ = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY_TAG  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_TAG    = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] field_limit;
        logic [BYTE_W-1:0] field_separator;
    } ftvt_cfg_t;

endpackage

// ----- hw/rtl/ftvt_if.sv -----
// ----------------------------------------------------------------------------
// ftvt channel interfaces
// byte request channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface ftvt_in_if;
    logic                         valid;
    logic                         ready;
    logic [ftvt_pkg::BYTE_W-1:0]  data_byte;
    logic                         end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ftvt_out_if;
    logic                          valid;
    logic                          ready;
    logic [ftvt_pkg::KIND_W-1:0]   kind;
    logic [ftvt_pkg::TAG_W-1:0]    tag_number;
    logic [ftvt_pkg::OFS_W-1:0]    value_offset;
    logic [ftvt_pkg::OFS_W-1:0]    value_length;
    logic [ftvt_pkg::INDEX_W-1:0]  field_index;
    logic [ftvt_pkg::ERR_W-1:0]    error_code;
    logic [ftvt_pkg::OFS_W-1:0]    error_position;
    logic                          final_result;

    modport source (output valid, output kind, output tag_number, output value_offset,
                    output value_length, output field_index, output error_code,
                    output error_position, output final_result, input ready);
    modport sink   (input valid, input kind, input tag_number, input value_offset,
                    input value_length, input field_index, input error_code,
                    input error_position, input final_result, output ready);
endinterface

// ----- hw/rtl/ftvt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ftvt_cfg_regs
// apb register file: field limit and field separator
// ----------------------------------------------------------------------------
module ftvt_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ftvt_pkg::APB_AW-1:0]   paddr,
    input  logic [ftvt_pkg::APB_DW-1:0]   pwdata,
    output logic [ftvt_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output ftvt_pkg::ftvt_cfg_t           cfg
);
    import ftvt_pkg::*;

    logic [BYTE_W-1:0] field_limit_reg;
    logic [BYTE_W-1:0] field_sep_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_limit_reg <= FIELD_LIMIT_RST;
            field_sep_reg   <= FIELD_SEP_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_FIELD_LIMIT: field_limit_reg <= pwdata[BYTE_W-1:0];
                REG_FIELD_SEP:   field_sep_reg   <= pwdata[BYTE_W-1:0];
                default:         field_limit_reg <= field_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIELD_LIMIT: prdata = {{(APB_DW-BYTE_W){1'b0}}, field_limit_reg};
            REG_FIELD_SEP:   prdata = {{(APB_DW-BYTE_W){1'b0}}, field_sep_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.field_limit     = field_limit_reg;
    assign cfg.field_separator = field_sep_reg;

endmodule

// ----- hw/rtl/ftvt_parser.sv -----
// ----------------------------------------------------------------------------
// ftvt_parser
// input register, per-byte field state machine and result register
// ----------------------------------------------------------------------------
module ftvt_parser #(
    parameter int TAG_BITS    = ftvt_pkg::TAG_BITS_DEF,
    parameter int OFFSET_BITS = ftvt_pkg::OFFSET_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ftvt_pkg::ftvt_cfg_t  cfg,
    ftvt_in_if.sink              stream,
    ftvt_out_if.source           result
);
    import ftvt_pkg::*;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_TAG   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_ERROR = 2'd3;

    localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

    // input register
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_fin_reg;
    logic              advance;

    // message state
    logic [1:0]             phase_reg,  phase_next;
    logic [TAG_BITS-1:0]    acc_reg,    acc_next;
    logic                   inv_reg,    inv_next;
    logic                   has_reg,    has_next;
    logic [OFFSET_BITS-1:0] fso_reg,    fso_next;
    logic [OFFSET_BITS-1:0] vso_reg,    vso_next;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next;
    logic [INDEX_W-1:0]     cnt_reg,    cnt_next;

    // result register
    logic                   out_vld_reg;
    logic [KIND_W-1:0]      kind_reg,   kind_next;
    logic [TAG_BITS-1:0]    tag_reg,    tag_next;
    logic [OFFSET_BITS-1:0] vofs_reg,   vofs_next;
    logic [OFFSET_BITS-1:0] vlen_reg,   vlen_next;
    logic [INDEX_W-1:0]     fidx_reg,   fidx_next;
    logic [ERR_W-1:0]       ecode_reg,  ecode_next;
    logic [OFFSET_BITS-1:0] epos_reg,   epos_next;
    logic                   fin_reg,    fin_next;
    logic                   emit;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] end_ofs;
    logic [TAG_BITS-1:0]    acc_base;
    logic [TAG_BITS+3:0]    tag_prod;
    logic [BYTE_W-1:0]      digit_diff;
    logic                   byte_numeric;

    logic [TAG_BITS+TAG_W-1:0]    tag_wide;
    logic [OFFSET_BITS+OFS_W-1:0] vofs_wide;
    logic [OFFSET_BITS+OFS_W-1:0] vlen_wide;
    logic [OFFSET_BITS+OFS_W-1:0] epos_wide;

    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign stream.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_vld_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg <= stream.data_byte;
            in_fin_reg  <= stream.end_of_message;
        end
    end

    assign pos_inc      = (pos_reg == OFS_MAX) ? OFS_MAX : pos_reg + 1'b1;
    assign end_ofs      = pos_inc;
    assign digit_diff   = in_byte_reg - ASCII_ZERO;
    assign byte_numeric = (in_byte_reg >= ASCII_ZERO) && (in_byte_reg <= ASCII_NINE);
    // a new field starts its tag from zero
    assign acc_base     = (phase_reg == PH_START) ? '0 : acc_reg;
    assign tag_prod     = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                        + {{TAG_BITS{1'b0}}, digit_diff[3:0]};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        inv_next   = inv_reg;
        has_next   = has_reg;
        fso_next   = fso_reg;
        vso_next   = vso_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        kind_next  = KIND_FIELD;
        tag_next   = '0;
        vofs_next  = '0;
        vlen_next  = '0;
        fidx_next  = cnt_reg;
        ecode_next = ERR_NONE;
        epos_next  = '0;
        fin_next   = in_fin_reg;

        // field start
        if (phase_reg == PH_START)
        begin
            phase_next = PH_TAG;
            acc_next   = '0;
            inv_next   = 1'b0;
            has_next   = 1'b0;
            fso_next   = pos_reg;
            if (cnt_reg >= cfg.field_limit)
            begin
                emit       = 1'b1;
                kind_next  = KIND_ERROR;
                ecode_next = ERR_TOO_MANY;
                epos_next  = pos_reg;
                phase_next = PH_ERROR;
            end
        end

        if (!emit && phase_next == PH_TAG)
        begin
            if (in_byte_reg == ASCII_EQ)
            begin
                if (!has_next)
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_ERROR;
                    ecode_next = ERR_EMPTY_TAG;
                    epos_next  = fso_next;
                    phase_next = PH_ERROR;
                end
                else if (inv_next)
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_ERROR;
                    ecode_next = ERR_BAD_TAG;
                    epos_next  = fso_next;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_VALUE;
                    vso_next   = pos_inc;
                    if (in_fin_reg)
                    begin
                        emit      = 1'b1;
                        tag_next  = acc_next;
                        vofs_next = pos_inc;
                    end
                end
            end
            else
            begin
                has_next = 1'b1;
                if (!byte_numeric)
                begin
                    inv_next = 1'b1;
                end
                else if (!inv_next)
                begin
                    // product above the tag range marks the tag invalid
                    if (tag_prod[TAG_BITS+3:TAG_BITS] != '0)
                    begin
                        inv_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = tag_prod[TAG_BITS-1:0];
                    end
                end
                if (in_fin_reg)
                begin
                    emit       = 1'b1;
                    kind_next  = KIND_ERROR;
                    ecode_next = ERR_MISSING_EQ;
                    epos_next  = fso_next;
                    phase_next = PH_ERROR;
                end
            end
        end
        else if (!emit && phase_next == PH_VALUE)
        begin
            if (in_byte_reg == cfg.field_separator)
            begin
                emit      = 1'b1;
                tag_next  = acc_reg;
                vofs_next = vso_reg;
                vlen_next = (pos_reg >= vso_reg) ? pos_reg - vso_reg : '0;
                if (cnt_reg != FIELD_COUNT_MAX)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                phase_next = PH_START;
            end
            else if (in_fin_reg)
            begin
                emit      = 1'b1;
                tag_next  = acc_reg;
                vofs_next = vso_reg;
                vlen_next = (end_ofs >= vso_reg) ? end_ofs - vso_reg : '0;
            end
        end

        if (in_fin_reg)
        begin
            phase_next = PH_START;
            acc_next   = '0;
            inv_next   = 1'b0;
            has_next   = 1'b0;
            fso_next   = '0;
            vso_next   = '0;
            pos_next   = '0;
            cnt_next   = '0;
        end
        else
        begin
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            inv_reg   <= 1'b0;
            has_reg   <= 1'b0;
            fso_reg   <= '0;
            vso_reg   <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            inv_reg   <= inv_next;
            has_reg   <= has_next;
            fso_reg   <= fso_next;
            vso_reg   <= vso_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg  <= kind_next;
            tag_reg   <= tag_next;
            vofs_reg  <= vofs_next;
            vlen_reg  <= vlen_next;
            fidx_reg  <= fidx_next;
            ecode_reg <= ecode_next;
            epos_reg  <= epos_next;
            fin_reg   <= fin_next;
        end
    end

    // resize internal widths to the fixed port widths
    assign tag_wide  = {{TAG_W{1'b0}}, tag_reg};
    assign vofs_wide = {{OFS_W{1'b0}}, vofs_reg};
    assign vlen_wide = {{OFS_W{1'b0}}, vlen_reg};
    assign epos_wide = {{OFS_W{1'b0}}, epos_reg};

    assign result.valid          = out_vld_reg;
    assign result.kind           = kind_reg;
    assign result.tag_number     = tag_wide[TAG_W-1:0];
    assign result.value_offset   = vofs_wide[OFS_W-1:0];
    assign result.value_length   = vlen_wide[OFS_W-1:0];
    assign result.field_index    = fidx_reg;
    assign result.error_code     = ecode_reg;
    assign result.error_position = epos_wide[OFS_W-1:0];
    assign result.final_result   = fin_reg;

endmodule

// ----- hw/rtl/fix_tag_value_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// fix_tag_value_tokenizer_unit
// streaming tokenizer for tag=value messages, one byte per request
// ----------------------------------------------------------------------------
// Takes one message byte per cycle and gives at most one result per byte: a
// parsed field (tag, value offset, value length, index) or the first error of
// the message. A byte held in the input register is parsed by combinational
// logic (including the multiply-by-ten tag update) into the result register
// when the byte advances, which waits while an earlier result is still held.
// One byte per clock is sustained while results are taken; a result held by
// the receiver stalls the input once the byte behind it fills the input
// register. The user must set field limit and separator over apb only while
// no message is in flight; the block itself does not enforce this.
module fix_tag_value_tokenizer_unit #(
    parameter int TAG_BITS    = ftvt_pkg::TAG_BITS_DEF,
    parameter int OFFSET_BITS = ftvt_pkg::OFFSET_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ftvt_pkg::APB_AW-1:0]   paddr,
    input  logic [ftvt_pkg::APB_DW-1:0]   pwdata,
    output logic [ftvt_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    ftvt_in_if.sink                       stream,
    ftvt_out_if.source                    result
);
    import ftvt_pkg::*;

    ftvt_cfg_t cfg;

    ftvt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ftvt_parser #(
        .TAG_BITS    (TAG_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .stream (stream),
        .result (result)
    );

endmodule

// ----- dv/ftvt_checker.sv -----
// ----------------------------------------------------------------------------
// ftvt_checker
// tracks the tokenizer's parse state and checks every result it emits
// ----------------------------------------------------------------------------
// Mirrors the field limit and separator registers from the apb writes. For
// each accepted byte it steps its own copy of the parse state and queues the
// token that byte should produce, if any. Each result taken from the block is
// checked field by field against the oldest queued token. The number of
// failures and the number of tokens still awaited go back to the top.
module ftvt_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [ftvt_pkg::APB_AW-1:0] paddr,
    input  logic [ftvt_pkg::APB_DW-1:0] pwdata,
    ftvt_in_if                          stream,
    ftvt_out_if                         result,
    output int                          errors,
    output int                          pending
);
    import ftvt_pkg::*;

    typedef enum logic [1:0] {AT_FIELD_START, IN_TAG, IN_VALUE, IN_ERROR} scan_phase_e;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   tag_number;
        logic [OFS_W-1:0]   value_offset;
        logic [OFS_W-1:0]   value_length;
        logic [INDEX_W-1:0] field_index;
        logic [ERR_W-1:0]   error_code;
        logic [OFS_W-1:0]   error_position;
        logic               final_result;
    } token_t;

    localparam logic [OFS_W-1:0] OFS_SAT = '1;
    localparam logic [TAG_W-1:0] TAG_SAT = '1;

    logic [BYTE_W-1:0]  limit_reg;
    logic [BYTE_W-1:0]  sep_reg;
    scan_phase_e        scan_phase;
    logic [TAG_W-1:0]   tag_acc;
    logic               tag_bad;
    logic               tag_seen;
    logic [OFS_W-1:0]   fld_begin;
    logic [OFS_W-1:0]   val_begin;
    logic [OFS_W-1:0]   byte_pos;
    logic [INDEX_W-1:0] fields_done;
    token_t             awaited_tokens[$];

    function automatic logic [OFS_W-1:0] step_offset(input logic [OFS_W-1:0] v);
        return (v == OFS_SAT) ? v : v + 1'b1;
    endfunction

    function automatic void clear_scan();
        scan_phase  = AT_FIELD_START;
        tag_acc     = '0;
        tag_bad     = 1'b0;
        tag_seen    = 1'b0;
        fld_begin   = '0;
        val_begin   = '0;
        byte_pos    = '0;
        fields_done = '0;
    endfunction

    function automatic token_t error_token(input logic [ERR_W-1:0] code,
                                           input logic [OFS_W-1:0] pos, input logic fin);
        token_t t;
        t = '0;
        t.kind           = KIND_ERROR;
        t.field_index    = fields_done;
        t.error_code     = code;
        t.error_position = pos;
        t.final_result   = fin;
        scan_phase = IN_ERROR;
        return t;
    endfunction

    function automatic token_t field_token(input logic [OFS_W-1:0] len, input logic fin);
        token_t t;
        t = '0;
        t.kind         = KIND_FIELD;
        t.tag_number   = tag_acc;
        t.value_offset = val_begin;
        t.value_length = len;
        t.field_index  = fields_done;
        t.error_code   = ERR_NONE;
        t.final_result = fin;
        return t;
    endfunction

    function automatic bit tokenize_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                         output token_t tok);
        logic [OFS_W-1:0] pos;
        logic [OFS_W-1:0] stop;
        logic [TAG_W-1:0] digit;
        bit               found;
        pos   = byte_pos;
        found = 0;
        tok   = '0;
        if (scan_phase == AT_FIELD_START)
        begin
            scan_phase  = IN_TAG;
            tag_acc     = '0;
            tag_bad     = 1'b0;
            tag_seen    = 1'b0;
            fld_begin   = pos;
            if (fields_done >= limit_reg)
            begin
                tok   = error_token(ERR_TOO_MANY, pos, fin);
                found = 1;
            end
        end
        if (!found && scan_phase == IN_TAG)
        begin
            if (b == ASCII_EQ)
            begin
                if (!tag_seen)
                begin
                    tok   = error_token(ERR_EMPTY_TAG, fld_begin, fin);
                    found = 1;
                end
                else if (tag_bad)
                begin
                    tok   = error_token(ERR_BAD_TAG, fld_begin, fin);
                    found = 1;
                end
                else
                begin
                    scan_phase = IN_VALUE;
                    val_begin  = step_offset(pos);
                    if (fin)
                    begin
                        tok   = field_token('0, 1'b1);
                        found = 1;
                    end
                end
            end
            else
            begin
                tag_seen = 1'b1;
                if (b >= ASCII_ZERO && b <= ASCII_NINE)
                begin
                    digit = TAG_W'(b - ASCII_ZERO);
                    if (!tag_bad)
                    begin
                        if (tag_acc > (TAG_SAT - digit) / 10)
                            tag_bad = 1'b1;
                        else
                            tag_acc = tag_acc * 10 + digit;
                    end
                end
                else
                begin
                    tag_bad = 1'b1;
                end
                if (fin)
                begin
                    tok   = error_token(ERR_MISSING_EQ, fld_begin, 1'b1);
                    found = 1;
                end
            end
        end
        else if (!found && scan_phase == IN_VALUE)
        begin
            if (b == sep_reg)
            begin
                tok   = field_token((pos >= val_begin) ? pos - val_begin : '0, fin);
                found = 1;
                if (fields_done != FIELD_COUNT_MAX)
                    fields_done = fields_done + 1'b1;
                scan_phase = AT_FIELD_START;
            end
            else if (fin)
            begin
                stop  = step_offset(pos);
                tok   = field_token((stop >= val_begin) ? stop - val_begin : '0, 1'b1);
                found = 1;
            end
        end
        if (fin)
            clear_scan();
        else
            byte_pos = step_offset(pos);
        return found;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_t tok;
        token_t want;
        if (!rst_n)
        begin
            limit_reg = FIELD_LIMIT_RST;
            sep_reg   = FIELD_SEP_RST;
            clear_scan();
            awaited_tokens.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_FIELD_LIMIT)
                    limit_reg = pwdata[BYTE_W-1:0];
                else
                    sep_reg = pwdata[BYTE_W-1:0];
            end
            if (stream.valid && stream.ready)
            begin
                if (tokenize_byte(stream.data_byte, stream.end_of_message, tok))
                    awaited_tokens.push_back(tok);
            end
            if (result.valid && result.ready)
            begin
                if (awaited_tokens.size() == 0)
                begin
                    $error("unexpected result: kind 0x%0h, tag 0x%0h",
                           result.kind, result.tag_number);
                    errors++;
                end
                else
                begin
                    want = awaited_tokens.pop_front();
                    check_field("kind", 32'(want.kind), 32'(result.kind));
                    check_field("tag_number", want.tag_number, result.tag_number);
                    check_field("value_offset", 32'(want.value_offset),
                                32'(result.value_offset));
                    check_field("value_length", 32'(want.value_length),
                                32'(result.value_length));
                    check_field("field_index", 32'(want.field_index),
                                32'(result.field_index));
                    check_field("error_code", 32'(want.error_code),
                                32'(result.error_code));
                    check_field("error_position", 32'(want.error_position),
                                32'(result.error_position));
                    check_field("final_result", 32'(want.final_result),
                                32'(result.final_result));
                end
            end
            pending = awaited_tokens.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the tag=value tokenizer
// ----------------------------------------------------------------------------
// Feeds messages into the tokenizer: a few hand-made ones first, then random
// messages that are mostly well formed fields with random tags and values,
// mixed with broken fields and noise. The field limit and separator are set
// between phases, the extremes among them, and one run of short fields goes
// past the largest field limit. Both channels stall at random; the checker
// beside the block predicts and compares every result.
module tb_top;
    import ftvt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                open_count;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                cycle_count = 0;
    bit                hold_req = 1'b0;
    logic [BYTE_W-1:0] msg_bytes[$];

    ftvt_in_if  stream_ch ();
    ftvt_out_if result_ch ();

    fix_tag_value_tokenizer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .stream  (stream_ch),
        .result  (result_ch)
    );

    ftvt_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .stream  (stream_ch),
        .result  (result_ch),
        .errors  (fail_count),
        .pending (open_count)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                for (int i = 0; i < 300; i++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            stream_ch.valid <= 1'b0;
            @(negedge clk);
        end
        stream_ch.valid          <= 1'b1;
        stream_ch.data_byte      <= b;
        stream_ch.end_of_message <= last;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task automatic send_text(input string s);
        msg_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            msg_bytes.push_back(s[i]);
        send_message();
    endtask

    task automatic drain();
        stream_ch.valid <= 1'b0;
        while (open_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_register(input logic which, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] limit, input logic [BYTE_W-1:0] sep);
        set_register(REG_FIELD_LIMIT, limit);
        set_register(REG_FIELD_SEP, sep);
    endtask

    // count fields of the form 12=<value><sep>, values free of the separator
    task automatic build_field_run(input logic [BYTE_W-1:0] sep, input int count,
                                   input int vlen);
        logic [BYTE_W-1:0] v;
        msg_bytes.delete();
        repeat (count)
        begin
            msg_bytes.push_back(ASCII_ZERO + 8'd1);
            msg_bytes.push_back(ASCII_ZERO + 8'd2);
            msg_bytes.push_back(ASCII_EQ);
            repeat (vlen)
            begin
                v = 8'($urandom_range(0, 255));
                if (v == sep)
                    v ^= 8'h80;
                msg_bytes.push_back(v);
            end
            msg_bytes.push_back(sep);
        end
    endtask

    task automatic build_message(input logic [BYTE_W-1:0] sep);
        int                nfields;
        int                ndig;
        int                pick;
        int                cut;
        logic [BYTE_W-1:0] v;
        msg_bytes.delete();
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 12))
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nfields = $urandom_range(1, 6);
        for (int f = 0; f < nfields; f++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                ndig = $urandom_range(1, 4);
            else if (pick < 80)
                ndig = $urandom_range(9, 11);
            else if (pick < 85)
                ndig = 0;
            else
                ndig = $urandom_range(1, 3);
            for (int d = 0; d < ndig; d++)
                msg_bytes.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
            // broken tags: a stray byte or the separator inside the digits
            if (pick >= 92)
            begin
                msg_bytes.push_back(sep);
                msg_bytes.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
            end
            else if (pick >= 85)
            begin
                msg_bytes.push_back(8'($urandom_range(0, 255)));
                msg_bytes.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(99) >= 4)
                msg_bytes.push_back(ASCII_EQ);
            repeat ($urandom_range(0, 8))
            begin
                v = 8'($urandom_range(0, 255));
                if (v == sep)
                    v ^= 8'h80;
                msg_bytes.push_back(v);
            end
            msg_bytes.push_back(sep);
        end
        // end on the separator, on the last value byte, or anywhere
        pick = $urandom_range(99);
        if (pick >= 85)
        begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut)
                void'(msg_bytes.pop_back());
        end
        else if (pick >= 50 && msg_bytes.size() > 1)
        begin
            void'(msg_bytes.pop_back());
        end
    endtask

    task automatic run_random(input logic [BYTE_W-1:0] sep, input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            build_message(sep);
            sent += msg_bytes.size();
            send_message();
        end
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        stream_ch.valid          = 1'b0;
        stream_ch.data_byte      = '0;
        stream_ch.end_of_message = 1'b0;
        tx_idle_pct              = 17;
        rx_idle_pct              = 63;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_text("4294967295=");
        send_text("=x");
        send_text("a=b");
        send_text("12");
        send_text("9=ab");
        msg_bytes.delete();
        msg_bytes.push_back(ASCII_ZERO + 8'd7);
        msg_bytes.push_back(ASCII_EQ);
        msg_bytes.push_back(FIELD_SEP_RST);
        send_message();
        drain();

        configure(8'd255, 8'h00);
        build_field_run(8'h00, 257, 0);
        send_message();
        run_random(8'h00, 150);
        drain();

        tx_idle_pct = 63;
        rx_idle_pct = 17;
        configure(8'd3, 8'h7C);
        hold_req = 1'b1;
        run_random(8'h7C, 120);
        drain();
        run_random(8'h7C, 120);
        drain();

        configure(8'd0, 8'hFF);
        run_random(8'hFF, 60);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(8'd8, ASCII_EQ);
        run_random(ASCII_EQ, 150);
        drain();

        configure(8'd200, FIELD_SEP_RST);
        run_random(FIELD_SEP_RST, 150);
        drain();

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
